// ----- rtl/dpre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data processing register execute package
// Word types, instruction field positions, operation codes and the structs
// passed between the register file, the ALU and the top level.
// ----------------------------------------------------------------------------
package dpre_pkg;

   // Instruction field positions.
   localparam int SF_BIT    = 31;
   localparam int OPC_HI    = 30;
   localparam int OPC_LO    = 29;
   localparam int MUL_BIT   = 28;
   localparam int OPR_HI    = 24;
   localparam int OPR_LO    = 21;
   localparam int RM_HI     = 20;
   localparam int RM_LO     = 16;
   localparam int IMM6_HI   = 15;
   localparam int IMM6_LO   = 10;
   localparam int RN_HI     = 9;
   localparam int RN_LO     = 5;
   localparam int RD_HI     = 4;
   localparam int RD_LO     = 0;

   // Shift types, taken from opr bits 2:1.
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   // Logical class operation codes.
   localparam logic [1:0] LOG_AND  = 2'd0;
   localparam logic [1:0] LOG_ORR  = 2'd1;
   localparam logic [1:0] LOG_EOR  = 2'd2;
   localparam logic [1:0] LOG_ANDS = 2'd3;

   localparam logic FUNC_EXEC = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] instruction;
      logic [4:0]  load_index;
      logic [63:0] load_value;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      logic        dest_written;
      logic [3:0]  flags;
   } rsp_word_type;

   typedef struct packed {
      logic       en;
      logic [4:0] rn;
      logic [4:0] rm;
      logic [4:0] ra;
   } rf_read_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [63:0] value;
   } rf_write_type;

   typedef struct packed {
      logic [63:0] rn;
      logic [63:0] rm;
      logic [63:0] ra;
   } rf_operands_type;

   typedef struct packed {
      logic [4:0]  dest_index;
      logic [63:0] value;
      logic [3:0]  flags;
   } alu_result_type;

endpackage

// ----- rtl/dpre_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register file
// Three replicated memories, one per read port, with registered read data,
// per-entry valid bits for the zero reset value and write-to-read forwarding.
// ----------------------------------------------------------------------------
module dpre_regfile #(
   parameter int NUM_REGS = 31
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dpre_pkg::rf_read_type     rd_req,
   input  dpre_pkg::rf_write_type    wr_req,
   output dpre_pkg::rf_operands_type operands
);
   import dpre_pkg::*;

   localparam int         IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [4:0] NUM_REGS_L = 5'(NUM_REGS);

   typedef enum logic [1:0] {SRC_ZERO, SRC_MEM, SRC_FWD} src_type;

   logic [NUM_REGS-1:0] valid_ff;
   logic [63:0]         wb_value_ff;
   logic [4:0]          rd_addr [3];
   logic [63:0]         rd_value [3];

   assign rd_addr[0] = rd_req.rn;
   assign rd_addr[1] = rd_req.rm;
   assign rd_addr[2] = rd_req.ra;

   // A read that meets a write to the same register in the same cycle takes
   // the written value from the write-back register instead of the memory.
   function automatic src_type pick_src(input logic [4:0] addr,
                                        input logic [NUM_REGS-1:0] valid,
                                        input rf_write_type wr);
      src_type src;
      src = SRC_ZERO;
      if (addr < NUM_REGS_L) begin
         if (wr.en && (wr.idx == addr)) begin
            src = SRC_FWD;
         end else if (valid[addr[IDX_W-1:0]]) begin
            src = SRC_MEM;
         end
      end
      return src;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_req.en) begin
         valid_ff[wr_req.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (wr_req.en) begin
         wb_value_ff <= wr_req.value;
      end
   end

   for (genvar p = 0; p < 3; p++) begin : g_port
      logic [63:0] mem [NUM_REGS];
      logic [63:0] data_ff;
      src_type     src_ff;
      logic [IDX_W-1:0] rd_idx;

      assign rd_idx = (rd_addr[p] < NUM_REGS_L) ? rd_addr[p][IDX_W-1:0] : '0;

      always_ff @(posedge clock) begin
         if (wr_req.en) begin
            mem[wr_req.idx[IDX_W-1:0]] <= wr_req.value;
         end
         if (rd_req.en) begin
            data_ff <= mem[rd_idx];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            src_ff <= SRC_ZERO;
         end else if (rd_req.en) begin
            src_ff <= pick_src(rd_addr[p], valid_ff, wr_req);
         end
      end

      always_comb begin
         case (src_ff)
            SRC_MEM: rd_value[p] = data_ff;
            SRC_FWD: rd_value[p] = wb_value_ff;
            default: rd_value[p] = '0;
         endcase
      end
   end

   assign operands.rn = rd_value[0];
   assign operands.rm = rd_value[1];
   assign operands.ra = rd_value[2];

endmodule

// ----- rtl/dpre_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execute ALU
// Decodes one word and computes multiply-add, shifted add/sub or logical
// results together with the next condition flags, or passes a load value on.
// ----------------------------------------------------------------------------
module dpre_alu (
   input  dpre_pkg::req_word_type    item,
   input  dpre_pkg::rf_operands_type ops,
   input  logic [3:0]                flags_cur,
   output dpre_pkg::alu_result_type  res
);
   import dpre_pkg::*;

   logic [31:0] ins;
   logic        wide;
   logic [63:0] mask;
   logic [63:0] a;
   logic [63:0] bm;
   logic [63:0] acc;
   logic [5:0]  imm6;
   logic [5:0]  amt;
   logic [3:0]  opr;
   logic [1:0]  opc;
   logic [63:0] p0;
   logic [31:0] p1;
   logic [31:0] p2;
   logic [63:0] prod;
   logic [63:0] mac;
   logic [63:0] sx;
   logic [63:0] asr_wide;
   logic [63:0] asr_narrow;
   logic [63:0] ror_narrow;
   logic [63:0] b;
   logic [64:0] sum;
   logic [64:0] diff;
   logic [63:0] value;
   logic        n_bit;
   logic        z_bit;
   logic        c_bit;
   logic        v_bit;
   logic        set_flags;

   assign ins  = item.instruction;
   assign wide = ins[SF_BIT];
   assign mask = wide ? {64{1'b1}} : {32'h0, {32{1'b1}}};
   assign imm6 = ins[IMM6_HI:IMM6_LO];
   assign amt  = wide ? imm6 : {1'b0, imm6[4:0]};
   assign opr  = ins[OPR_HI:OPR_LO];
   assign opc  = ins[OPC_HI:OPC_LO];
   assign a    = ops.rn & mask;
   assign bm   = ops.rm & mask;
   assign acc  = ops.ra & mask;

   // Low 64 bits of the product from three partial products of 32-bit halves.
   assign p0   = a[31:0] * bm[31:0];
   assign p1   = 32'(a[31:0] * bm[63:32]);
   assign p2   = 32'(a[63:32] * bm[31:0]);
   assign prod = p0 + {p1 + p2, 32'h0};
   assign mac  = (imm6[5] ? (acc - prod) : (acc + prod)) & mask;

   assign sx         = {{32{bm[31]}}, bm[31:0]};
   assign asr_wide   = $signed(bm) >>> amt;
   assign asr_narrow = ($signed(sx) >>> amt) & mask;
   assign ror_narrow = {32'h0, 32'({bm[31:0], bm[31:0]} >> amt)};

   always_comb begin
      case (opr[2:1])
         SH_LSL:  b = (bm << amt) & mask;
         SH_LSR:  b = bm >> amt;
         SH_ASR:  b = wide ? asr_wide : asr_narrow;
         SH_ROR:  b = wide ? ((bm >> amt) | (bm << (7'd64 - {1'b0, amt}))) : ror_narrow;
         default: b = bm;
      endcase
   end

   assign sum  = {1'b0, a} + {1'b0, b};
   assign diff = {1'b0, a} - {1'b0, b};

   always_comb begin
      value     = '0;
      c_bit     = 1'b0;
      v_bit     = 1'b0;
      set_flags = 1'b0;
      if (ins[MUL_BIT]) begin
         value = mac;
      end else if (opr[3]) begin
         set_flags = opc[0];
         if (opc[1]) begin
            value = diff[63:0] & mask;
            c_bit = ~diff[64];
            v_bit = wide ? ((a[63] ^ b[63]) & (a[63] ^ value[63]))
                         : ((a[31] ^ b[31]) & (a[31] ^ value[31]));
         end else begin
            value = sum[63:0] & mask;
            c_bit = wide ? sum[64] : sum[32];
            v_bit = wide ? (~(a[63] ^ b[63]) & (a[63] ^ value[63]))
                         : (~(a[31] ^ b[31]) & (a[31] ^ value[31]));
         end
      end else begin
         case (opc)
            LOG_ORR:  value = a | ((opr[0] ? ~b : b) & mask);
            LOG_EOR:  value = a ^ ((opr[0] ? ~b : b) & mask);
            LOG_AND,
            LOG_ANDS: value = a & ((opr[0] ? ~b : b) & mask);
            default:  value = '0;
         endcase
         set_flags = (opc == LOG_ANDS);
      end
   end

   assign n_bit = wide ? value[63] : value[31];
   assign z_bit = (value == 64'h0);

   always_comb begin
      if (item.func == FUNC_LOAD) begin
         res.dest_index = item.load_index;
         res.value      = item.load_value;
         res.flags      = flags_cur;
      end else begin
         res.dest_index = ins[RD_HI:RD_LO];
         res.value      = value;
         res.flags      = set_flags ? {n_bit, z_bit, c_bit, v_bit} : flags_cur;
      end
   end

endmodule

// ----- rtl/data_processing_register_execute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data processing register execute
// AArch64 data-processing (register) execute stage with its own register
// file of 64-bit registers and NZCV flags.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   req       in         req_valid/req_ready    req_word (func, instruction,
//                                               load_index, load_value)
//   rsp       out        rsp_valid/rsp_ready    rsp_word (dest_index,
//                                               dest_value, dest_written, flags)
//
// One word per cycle unless the result side stalls. At acceptance the source
// registers are read into the register file's read registers; in the next
// cycle the ALU computes the result, which is written back and loaded into the
// result register at the same edge. The 64-bit multiply-add in the ALU sets
// the length of the execute cycle.
// Reset clears the valid bits of the register file (registers read as zero),
// the flags and both valid stages; no clearing pass is needed.
// A stalled result holds the result register; the execute stage still takes
// a new word when it is empty, so one word can wait on each side.
//
module data_processing_register_execute #(
   parameter int NUM_REGS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dpre_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dpre_pkg::rsp_word_type rsp_word
);
   import dpre_pkg::*;

   localparam logic [4:0] NUM_REGS_L = 5'(NUM_REGS);

   logic            ex_valid_ff;
   req_word_type    ex_word_ff;
   logic            rsp_valid_ff;
   rsp_word_type    rsp_ff;
   logic [3:0]      flags_ff;

   logic            req_take;
   logic            ex_move;
   logic            dest_written;
   rf_read_type     rd_req;
   rf_write_type    wr_req;
   rf_operands_type operands;
   alu_result_type  alu_res;

   // The execute stage moves forward whenever the result register is empty
   // or is being emptied in this cycle.
   assign ex_move   = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !ex_valid_ff || ex_move;
   assign req_take  = req_valid && req_ready;

   // Source registers are addressed straight from the incoming word, so the
   // read data is ready in the execute cycle. Register 31 (and any number at
   // or above the register count) reads as zero.
   assign rd_req.en = req_take;
   assign rd_req.rn = req_word.instruction[RN_HI:RN_LO];
   assign rd_req.rm = req_word.instruction[RM_HI:RM_LO];
   assign rd_req.ra = req_word.instruction[IMM6_LO+4:IMM6_LO];

   dpre_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_req   (rd_req),
      .wr_req   (wr_req),
      .operands (operands)
   );

   dpre_alu u_alu (
      .item      (ex_word_ff),
      .ops       (operands),
      .flags_cur (flags_ff),
      .res       (alu_res)
   );

   // Writes to register 31 or to an unbuilt register are dropped, but the
   // value is still reported.
   assign dest_written = (alu_res.dest_index < NUM_REGS_L);
   assign wr_req.en    = ex_move && dest_written;
   assign wr_req.idx   = alu_res.dest_index;
   assign wr_req.value = alu_res.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_take) begin
            ex_valid_ff <= 1'b1;
         end else if (ex_move) begin
            ex_valid_ff <= 1'b0;
         end
         if (ex_move) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= alu_res.flags;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ex_word_ff <= req_word;
      end
      if (ex_move) begin
         rsp_ff.dest_index   <= alu_res.dest_index;
         rsp_ff.dest_value   <= alu_res.value;
         rsp_ff.dest_written <= dest_written;
         rsp_ff.flags        <= alu_res.flags;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
